// ----- hw/rtl/cvs_pkg.sv -----
`timescale 1ns / 1ps

package cvs_pkg;

	// Field widths, fixed by the interface.
	localparam int RAW_W    = 16;
	localparam int GAIN_W   = 9;
	localparam int OFFSET_W = 8;
	localparam int LABEL_W  = 4;
	localparam int MAP_W    = 36;
	localparam int MV_W     = 16;
	localparam int PACK_W   = 20;
	localparam int CFG_W    = MAP_W;

	// Default number of cells in one scan.
	localparam int CELLS_DEF = 9;

	// Number of label slots in the label map.
	localparam int LABEL_SLOTS = MAP_W / LABEL_W;

	// Product raw_adc * gain never exceeds 65535 * 511 < 2^25.
	localparam int PROD_W = RAW_W + GAIN_W;

	// Division by 1000 is done as a shift by 3 followed by an exact
	// reciprocal multiplication for the division by 125.
	localparam int                  PRESHIFT    = 3;
	localparam int                  DIVIN_W     = PROD_W - PRESHIFT;
	localparam int                  RECIP_W     = 23;
	localparam logic [RECIP_W-1:0]  RECIP       = 23'd4294968;
	localparam int                  RECIP_SHIFT = 29;

	// Reset values of the configuration registers.
	localparam logic [GAIN_W-1:0]   GAIN_RESET      = 9'd380;
	localparam logic [OFFSET_W-1:0] OFFSET_RESET    = 8'd0;
	localparam logic [MAP_W-1:0]    LABEL_MAP_RESET = 36'hFCBA76521;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_GAIN      = 2'd0,
		CFG_OFFSET    = 2'd1,
		CFG_LABEL_MAP = 2'd2
	} cfg_idx_t;

	// Load strobes for the two scaling stages.
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
	} scale_ctl_t;

endpackage

// ----- hw/rtl/cvs_scale.sv -----
`timescale 1ns / 1ps

module cvs_scale (
	input  logic                          clk,
	input  cvs_pkg::scale_ctl_t           ctl,
	input  logic [cvs_pkg::RAW_W-1:0]     raw_adc,
	input  logic [cvs_pkg::GAIN_W-1:0]    gain,
	output logic [cvs_pkg::MV_W-1:0]      quot
);
	import cvs_pkg::*;

	logic [PROD_W-1:0]          prod_s1;
	logic [MV_W-1:0]            quot_s2;
	logic [DIVIN_W-1:0]         divin;
	logic [DIVIN_W+RECIP_W-1:0] recip_prod;

	// First stage: raw word times gain in microvolts.
	always_ff @(posedge clk) begin
		if (ctl.ld_s1) begin
			prod_s1 <= PROD_W'(raw_adc) * PROD_W'(gain);
		end
	end

	// Second stage: floor(prod / 1000) = floor(floor(prod / 8) / 125).
	assign divin      = prod_s1[PROD_W-1:PRESHIFT];
	assign recip_prod = (DIVIN_W+RECIP_W)'(divin) * (DIVIN_W+RECIP_W)'(RECIP);

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			quot_s2 <= MV_W'(recip_prod >> RECIP_SHIFT);
		end
	end

	assign quot = quot_s2;

endmodule

// ----- hw/rtl/cvs_stats.sv -----
`timescale 1ns / 1ps

module cvs_stats #(
	parameter int CELLS = cvs_pkg::CELLS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          ld,
	input  logic [cvs_pkg::MV_W-1:0]      quot,
	input  logic [cvs_pkg::OFFSET_W-1:0]  offset,
	input  logic [cvs_pkg::MAP_W-1:0]     label_map,
	output logic [cvs_pkg::MV_W-1:0]      cell_mv,
	output logic                          scan_done,
	output logic [cvs_pkg::MV_W-1:0]      max_mv,
	output logic [cvs_pkg::MV_W-1:0]      min_mv,
	output logic [cvs_pkg::MV_W-1:0]      spread_mv,
	output logic [cvs_pkg::LABEL_W-1:0]   max_label,
	output logic [cvs_pkg::LABEL_W-1:0]   min_label,
	output logic [cvs_pkg::PACK_W-1:0]    pack_mv
);
	import cvs_pkg::*;

	localparam int POS_W = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int SUM_W = MV_W + 2;

	logic [POS_W-1:0]   pos_q;
	logic [MV_W-1:0]    max_q;
	logic [MV_W-1:0]    min_q;
	logic [POS_W-1:0]   max_pos_q;
	logic [POS_W-1:0]   min_pos_q;
	logic [PACK_W-1:0]  sum_q;

	logic [MV_W-1:0]    cell_mv_q;
	logic               scan_done_q;
	logic [MV_W-1:0]    max_mv_q;
	logic [MV_W-1:0]    min_mv_q;
	logic [MV_W-1:0]    spread_mv_q;
	logic [LABEL_W-1:0] max_label_q;
	logic [LABEL_W-1:0] min_label_q;
	logic [PACK_W-1:0]  pack_mv_q;

	logic signed [SUM_W-1:0] with_off;
	logic [MV_W-1:0]         mv;
	logic                    first;
	logic                    last;
	logic [MV_W-1:0]         nmax;
	logic [MV_W-1:0]         nmin;
	logic [POS_W-1:0]        nmax_pos;
	logic [POS_W-1:0]        nmin_pos;
	logic [PACK_W-1:0]       nsum;
	logic [LABEL_W-1:0]      labels [LABEL_SLOTS];
	logic [3:0]              max_idx;
	logic [3:0]              min_idx;
	logic [LABEL_W-1:0]      nmax_label;
	logic [LABEL_W-1:0]      nmin_label;

	// Offset and clamp to the millivolt range.
	assign with_off = $signed({2'b00, quot}) + SUM_W'($signed(offset));

	always_comb begin
		if (with_off[SUM_W-1]) begin
			mv = '0;
		end else if (with_off[SUM_W-2:MV_W] != '0) begin
			mv = '1;
		end else begin
			mv = with_off[MV_W-1:0];
		end
	end

	assign first = (pos_q == '0);
	assign last  = (pos_q == POS_W'(CELLS - 1));

	// Strict compares keep the earliest cell on a tie.
	always_comb begin
		if (first) begin
			nmax     = mv;
			nmin     = mv;
			nmax_pos = '0;
			nmin_pos = '0;
			nsum     = PACK_W'(mv);
		end else begin
			nmax     = max_q;
			nmin     = min_q;
			nmax_pos = max_pos_q;
			nmin_pos = min_pos_q;
			nsum     = sum_q + PACK_W'(mv);
			if (mv > max_q) begin
				nmax     = mv;
				nmax_pos = pos_q;
			end
			if (mv < min_q) begin
				nmin     = mv;
				nmin_pos = pos_q;
			end
		end
	end

	// Positions past the label map read as label zero.
	always_comb begin
		for (int i = 0; i < LABEL_SLOTS; i++) begin
			labels[i] = label_map[i*LABEL_W +: LABEL_W];
		end
	end

	assign max_idx    = 4'(nmax_pos);
	assign min_idx    = 4'(nmin_pos);
	assign nmax_label = (max_idx < 4'(LABEL_SLOTS)) ? labels[max_idx] : '0;
	assign nmin_label = (min_idx < 4'(LABEL_SLOTS)) ? labels[min_idx] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			max_q     <= '0;
			min_q     <= '0;
			max_pos_q <= '0;
			min_pos_q <= '0;
			sum_q     <= '0;
		end else if (ld) begin
			if (last) begin
				pos_q     <= '0;
				max_q     <= '0;
				min_q     <= '0;
				max_pos_q <= '0;
				min_pos_q <= '0;
				sum_q     <= '0;
			end else begin
				pos_q     <= pos_q + POS_W'(1);
				max_q     <= nmax;
				min_q     <= nmin;
				max_pos_q <= nmax_pos;
				min_pos_q <= nmin_pos;
				sum_q     <= nsum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			cell_mv_q   <= mv;
			scan_done_q <= last;
			max_mv_q    <= last ? nmax : '0;
			min_mv_q    <= last ? nmin : '0;
			spread_mv_q <= last ? (nmax - nmin) : '0;
			max_label_q <= last ? nmax_label : '0;
			min_label_q <= last ? nmin_label : '0;
			pack_mv_q   <= last ? nsum : '0;
		end
	end

	assign cell_mv   = cell_mv_q;
	assign scan_done = scan_done_q;
	assign max_mv    = max_mv_q;
	assign min_mv    = min_mv_q;
	assign spread_mv = spread_mv_q;
	assign max_label = max_label_q;
	assign min_label = min_label_q;
	assign pack_mv   = pack_mv_q;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(CELLS - 1))
		else $error("scan position ran past the last cell");

	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		ld && last |=> pos_q == '0)
		else $error("scan did not restart after its last cell");

	a_stats: assert property (@(posedge clk) disable iff (!arst_n)
		ld && last |=> scan_done_q && max_mv_q >= min_mv_q &&
			spread_mv_q == max_mv_q - min_mv_q)
		else $error("scan statistics are inconsistent");

endmodule

// ----- hw/rtl/cell_voltage_scale_and_stats.sv -----
`timescale 1ns / 1ps

// Cell voltage scaling and scan statistics. Each request carries one raw cell
// ADC word, in scan order over CELLS channels, and yields exactly one result:
// the cell voltage in millivolts, floor(raw_adc * gain / 1000) + offset,
// clamped to 0..65535. On the last cell of a scan the result also carries the
// highest and lowest cell voltage, their difference, the board labels of
// those two cells and the pack total, and the block then starts a new scan;
// on every other cell those fields read zero. A tie keeps the earlier cell.
// The block takes one request per cycle while adc_stall is low; each request
// passes through three register stages in order: the gain multiplier, the
// reciprocal multiplier that divides by 1000, and the offset, clamp and
// statistics update in front of the result register. Requests keep flowing
// while a result is stalled until all three stages hold an item.
// Configuration registers are written through cfg_we, cfg_index and cfg_data
// (0: gain, 1: offset, 2: label map), only while no request is in flight;
// the user must keep to this unenforced rule; writes to index 3 are ignored.

module cell_voltage_scale_and_stats #(
	parameter int CELLS = cvs_pkg::CELLS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [cvs_pkg::CFG_W-1:0]     cfg_data,

	input  logic                          adc_valid,
	output logic                          adc_stall,
	input  logic [cvs_pkg::RAW_W-1:0]     raw_adc,

	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [cvs_pkg::MV_W-1:0]      cell_mv,
	output logic                          scan_done,
	output logic [cvs_pkg::MV_W-1:0]      max_mv,
	output logic [cvs_pkg::MV_W-1:0]      min_mv,
	output logic [cvs_pkg::MV_W-1:0]      spread_mv,
	output logic [cvs_pkg::LABEL_W-1:0]   max_label,
	output logic [cvs_pkg::LABEL_W-1:0]   min_label,
	output logic [cvs_pkg::PACK_W-1:0]    pack_mv
);
	import cvs_pkg::*;

	// Configuration registers.
	logic [GAIN_W-1:0]   gain_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [MAP_W-1:0]    label_map_q;

	// Occupancy of the pipeline stages.
	logic v_s1_q;
	logic v_s2_q;
	logic res_valid_q;

	// A stage may load when it is empty or its content moves on this cycle.
	logic       en_out;
	logic       en_s2;
	logic       en_s1;
	logic       ld_out;
	scale_ctl_t scale_ctl;
	logic [MV_W-1:0] quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q      <= GAIN_RESET;
			offset_q    <= OFFSET_RESET;
			label_map_q <= LABEL_MAP_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_GAIN: begin
					gain_q <= cfg_data[GAIN_W-1:0];
				end
				CFG_OFFSET: begin
					offset_q <= cfg_data[OFFSET_W-1:0];
				end
				CFG_LABEL_MAP: begin
					label_map_q <= cfg_data[MAP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Stall propagates backward only through full stages, so bubbles are
	// squeezed out while the consumer holds a result.
	assign en_out = !res_valid_q || !res_stall;
	assign en_s2  = !v_s2_q || en_out;
	assign en_s1  = !v_s1_q || en_s2;

	assign adc_stall       = !en_s1;
	assign scale_ctl.ld_s1 = adc_valid && en_s1;
	assign scale_ctl.ld_s2 = v_s1_q && en_s2;
	assign ld_out          = v_s2_q && en_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q      <= 1'b0;
			v_s2_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1_q <= adc_valid;
			end
			if (en_s2) begin
				v_s2_q <= v_s1_q;
			end
			if (en_out) begin
				res_valid_q <= v_s2_q;
			end
		end
	end

	// Gain multiply and division by 1000.
	cvs_scale u_scale (
		.clk     (clk),
		.ctl     (scale_ctl),
		.raw_adc (raw_adc),
		.gain    (gain_q),
		.quot    (quot)
	);

	// Offset, clamp, running statistics and the result register.
	cvs_stats #(
		.CELLS (CELLS)
	) u_stats (
		.clk       (clk),
		.arst_n    (arst_n),
		.ld        (ld_out),
		.quot      (quot),
		.offset    (offset_q),
		.label_map (label_map_q),
		.cell_mv   (cell_mv),
		.scan_done (scan_done),
		.max_mv    (max_mv),
		.min_mv    (min_mv),
		.spread_mv (spread_mv),
		.max_label (max_label),
		.min_label (min_label),
		.pack_mv   (pack_mv)
	);

	assign res_valid = res_valid_q;

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1_q && v_s2_q && res_valid_q && res_stall |-> adc_stall)
		else $error("request accepted into a full pipeline");

	a_bubble_take: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1_q |-> !adc_stall)
		else $error("request stalled while the first stage is empty");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2_q && en_out |=> res_valid_q)
		else $error("item lost between the last stage and the result register");

endmodule
